FILE: sv/mie_pkg.sv
// ----------------------------------------------------------------------------
// Modular inverse package
// Shared width constants and the sequencer state type of the modular
// inverse block.
// ----------------------------------------------------------------------------
package mie_pkg;

  localparam int unsigned WIDTH = 32;
  localparam int unsigned CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DIV    = 5'b00010,
    ST_STEP   = 5'b00100,
    ST_FOLD   = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

endpackage

FILE: sv/modular_inverse_extended_euclid.sv
// ----------------------------------------------------------------------------
// Modular inverse by the extended Euclidean algorithm
// Returns the inverse of a value modulo a modulus, or a no-inverse flag.
// ----------------------------------------------------------------------------
// One request is worked on at a time; in_ready_o is high only while the
// sequencer is idle. A single restoring divider, one quotient bit per
// cycle, performs every division: first the reduction of the value by the
// modulus, then one division per Euclid round, while the Bezout
// coefficient is built from the quotient bits by shift and add as they
// appear. After each division the step state updates the coefficients;
// the number of rounds R is at most about 1.44 * WIDTH and is much smaller
// for typical operands. A modulus below two skips the divisions and goes
// straight to the finishing state. The result sits in an output register,
// so the next request can be accepted while it waits.
module modular_inverse_extended_euclid
  import mie_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] modulus_i,
  input  logic [WIDTH-1:0] operand_value_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] inverse_o,
  output logic             no_inverse_o
);

  state_e state_q, state_d;

  logic [WIDTH-1:0] m_q, m_d;
  logic [WIDTH-1:0] dvd_q, dvd_d;
  logic [WIDTH-1:0] dvs_q, dvs_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] prev_q, prev_d;
  logic [WIDTH-1:0] cur_q, cur_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             neg_q, neg_d;
  logic             first_q, first_d;
  logic             none_q, none_d;
  logic             out_valid_q, out_valid_d;
  logic [WIDTH-1:0] inv_q, inv_d;
  logic             noinv_q, noinv_d;

  logic [WIDTH:0]   rem_shift;
  logic             rem_ge;
  logic [WIDTH:0]   rem_diff;
  logic             in_fire;
  logic             out_load;

  assign in_ready_o   = (state_q == ST_IDLE);
  assign in_fire      = in_valid_i && in_ready_o;
  assign out_valid_o  = out_valid_q;
  assign inverse_o    = inv_q;
  assign no_inverse_o = noinv_q;

  assign rem_shift = {rem_q, dvd_q[WIDTH-1]};
  assign rem_ge    = (rem_shift >= {1'b0, dvs_q});
  assign rem_diff  = rem_shift - {1'b0, dvs_q};
  assign out_load  = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    m_d         = m_q;
    dvd_d       = dvd_q;
    dvs_d       = dvs_q;
    rem_d       = rem_q;
    acc_d       = acc_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    first_d     = first_q;
    none_d      = none_q;
    inv_d       = inv_q;
    noinv_d     = noinv_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          m_d     = modulus_i;
          dvd_d   = operand_value_i;
          dvs_d   = modulus_i;
          rem_d   = '0;
          acc_d   = '0;
          cnt_d   = '0;
          prev_d  = '0;
          cur_d   = {{(WIDTH-1){1'b0}}, 1'b1};
          neg_d   = 1'b0;
          first_d = 1'b1;
          if (modulus_i < {{(WIDTH-2){1'b0}}, 2'b10}) begin
            none_d  = 1'b1;
            state_d = ST_FINISH;
          end else begin
            none_d  = 1'b0;
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_d = rem_ge ? rem_diff[WIDTH-1:0] : rem_shift[WIDTH-1:0];
        dvd_d = {dvd_q[WIDTH-2:0], 1'b0};
        acc_d = {acc_q[WIDTH-2:0], 1'b0} + (rem_ge ? cur_q : '0);
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(WIDTH - 1)) begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        if (!first_q) begin
          prev_d = cur_q;
          cur_d  = prev_q + acc_q;
          neg_d  = ~neg_q;
        end
        first_d = 1'b0;
        if (rem_q > {{(WIDTH-1){1'b0}}, 1'b1}) begin
          dvd_d   = dvs_q;
          dvs_d   = rem_q;
          rem_d   = '0;
          acc_d   = '0;
          cnt_d   = '0;
          state_d = ST_DIV;
        end else begin
          none_d  = (rem_q != {{(WIDTH-1){1'b0}}, 1'b1});
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (cur_q >= m_q) begin
          cur_d = cur_q - m_q;
        end
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) begin
          if (none_q) begin
            inv_d = '0;
          end else if (neg_q && (cur_q != '0)) begin
            inv_d = m_q - cur_q;
          end else begin
            inv_d = cur_q;
          end
          noinv_d     = none_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      first_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      first_q     <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q     <= m_d;
    dvd_q   <= dvd_d;
    dvs_q   <= dvs_d;
    rem_q   <= rem_d;
    acc_q   <= acc_d;
    prev_q  <= prev_d;
    cur_q   <= cur_d;
    neg_q   <= neg_d;
    none_q  <= none_d;
    inv_q   <= inv_d;
    noinv_q <= noinv_d;
  end

`ifndef ASSERT_OFF
  // A result without an inverse always carries zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_inverse_o |-> inverse_o == '0)
    else $error("no-inverse result with non-zero inverse");

  // The running remainder never reaches the divisor during a division.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> rem_q < dvs_q)
    else $error("divider remainder not below divisor");

  // Euclid rounds only ever divide by a value above one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV && !first_q |-> dvs_q > {{(WIDTH-1){1'b0}}, 1'b1})
    else $error("division round started with divisor below two");

  // An accepted request always leaves the idle state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q != ST_IDLE)
    else $error("accepted request did not start the sequencer");

  // A finished result is never dropped while the output register is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FINISH && out_valid_q && !out_ready_i |=> state_q == ST_FINISH)
    else $error("result left the sequencer while output was stalled");
`endif

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular inverse testbench
// Sends modulus and value requests to the modular inverse block, predicts
// each inverse and no-inverse flag, and compares them with the results in
// order. A directed table and two fixed requests come first, followed by
// random requests, with random idling on both handshakes.
// ----------------------------------------------------------------------------
module tb_top;
  import mie_pkg::*;

  localparam int unsigned RANDOM_REQUESTS = 1000;
  localparam int unsigned WATCHDOG_LIMIT  = 20000;
  localparam int unsigned DRAIN_CYCLES    = 64;
  localparam int unsigned MAX_IDLE        = 18;

  typedef struct packed {
    logic [WIDTH-1:0] inverse;
    logic             no_inverse;
  } inverse_t;

  typedef struct packed {
    logic [WIDTH-1:0] modulus;
    logic [WIDTH-1:0] operand_value;
    logic [WIDTH-1:0] inverse;
    logic             no_inverse;
    logic             typed_in;
  } directed_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [WIDTH-1:0] modulus_i;
  logic [WIDTH-1:0] operand_value_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [WIDTH-1:0] inverse_o;
  logic             no_inverse_o;

  inverse_t      pending_inverses[$];
  directed_row_t directed_rows[18];
  int unsigned   error_count;
  int unsigned   quiet_cycles;

  modular_inverse_extended_euclid DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .modulus_i      (modulus_i),
    .operand_value_i(operand_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .inverse_o      (inverse_o),
    .no_inverse_o   (no_inverse_o)
  );

  function automatic inverse_t compute_inverse(logic [WIDTH-1:0] m, logic [WIDTH-1:0] v);
    logic [2*WIDTH-1:0] a;
    logic [2*WIDTH-1:0] b;
    logic [2*WIDTH-1:0] q;
    logic [2*WIDTH-1:0] r;
    logic [2*WIDTH-1:0] prev_mag;
    logic [2*WIDTH-1:0] cur_mag;
    logic [2*WIDTH-1:0] next_mag;
    logic [2*WIDTH-1:0] red;
    logic               negative;
    inverse_t           res;
    res.inverse    = '0;
    res.no_inverse = 1'b1;
    if (m >= 2) begin
      a        = m;
      b        = v % m;
      prev_mag = 0;
      cur_mag  = 1;
      negative = 1'b0;
      while (b > 1) begin
        q        = a / b;
        r        = a % b;
        next_mag = prev_mag + q * cur_mag;
        prev_mag = cur_mag;
        cur_mag  = next_mag;
        negative = !negative;
        a        = b;
        b        = r;
      end
      if (b == 1) begin
        red            = cur_mag % m;
        res.no_inverse = 1'b0;
        if (negative) begin
          res.inverse = (red == 0) ? '0 : WIDTH'(m - red);
        end else begin
          res.inverse = WIDTH'(red);
        end
      end
    end
    return res;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_request(input logic [WIDTH-1:0] m, input logic [WIDTH-1:0] v,
                              input inverse_t expected, input int unsigned gap);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    modulus_i       <= m;
    operand_value_i <= v;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    pending_inverses.push_back(expected);
  endtask

  initial begin
    logic [WIDTH-1:0] m;
    logic [WIDTH-1:0] v;
    logic [WIDTH-1:0] g;
    inverse_t         expected;
    logic             burst;
    int unsigned      gap;

    in_valid_i      = 1'b0;
    modulus_i       = '0;
    operand_value_i = '0;
    rst_ni          = 1'b0;
    error_count     = 0;
    burst           = 1'b0;

    directed_rows = '{
      '{32'd0,          32'd0,          32'd0,          1'b1, 1'b1},
      '{32'd0,          32'hFFFF_FFFF,  32'd0,          1'b1, 1'b1},
      '{32'd1,          32'd5,          32'd0,          1'b1, 1'b1},
      '{32'd2,          32'd0,          32'd0,          1'b1, 1'b1},
      '{32'd2,          32'd1,          32'd1,          1'b0, 1'b1},
      '{32'd2,          32'hFFFF_FFFF,  32'd1,          1'b0, 1'b1},
      '{32'd3,          32'd2,          32'd2,          1'b0, 1'b1},
      '{32'hFFFF_FFFF,  32'd0,          32'd0,          1'b1, 1'b1},
      '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'd0,          1'b1, 1'b1},
      '{32'hFFFF_FFFF,  32'd1,          32'd1,          1'b0, 1'b1},
      '{32'hFFFF_FFFF,  32'hFFFF_FFFE,  32'hFFFF_FFFE,  1'b0, 1'b1},
      '{32'hFFFF_FFFF,  32'd3,          32'd0,          1'b1, 1'b1},
      '{32'd10,         32'd4,          32'd0,          1'b1, 1'b1},
      '{32'd7,          32'd10,         32'd5,          1'b0, 1'b1},
      '{32'h8000_0000,  32'h8000_0001,  32'd1,          1'b0, 1'b1},
      '{32'h8000_0000,  32'h7FFF_FFFF,  32'h7FFF_FFFF,  1'b0, 1'b1},
      '{32'd3120,       32'd17,         32'd2753,       1'b0, 1'b1},
      '{32'd2971215073, 32'd1836311903, 32'd0,          1'b0, 1'b0}
    };

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].typed_in) begin
        expected.inverse    = directed_rows[i].inverse;
        expected.no_inverse = directed_rows[i].no_inverse;
      end else begin
        expected = compute_inverse(directed_rows[i].modulus, directed_rows[i].operand_value);
      end
      send_request(directed_rows[i].modulus, directed_rows[i].operand_value, expected,
                   $urandom_range(0, MAX_IDLE));
    end
    send_request(32'd4294967291, 32'd2, '{32'd2147483646, 1'b0}, 0);
    send_request(32'hDEAD_BEEF, 32'h1234_5678, compute_inverse(32'hDEAD_BEEF, 32'h1234_5678), 0);

    for (int unsigned n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 50 == 0) burst = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: begin
          m = $urandom_range(0, 3);
          v = $urandom;
        end
        1: begin
          m = $urandom_range(2, 65535);
          v = m * $urandom_range(0, 65535);
        end
        2: begin
          g = $urandom_range(2, 1000);
          m = g * $urandom_range(1, 4000000);
          v = g * $urandom_range(0, 4000000);
        end
        3: begin
          m = $urandom;
          v = ($urandom_range(0, 1) == 1) ? m + 1 : m - 1;
        end
        4: begin
          m = $urandom | 32'd1;
          v = $urandom_range(0, 255);
        end
        5: begin
          m = $urandom_range(2, 1000);
          v = $urandom;
        end
        default: begin
          m = $urandom;
          v = $urandom;
        end
      endcase
      send_request(m, v, compute_inverse(m, v), burst ? 0 : $urandom_range(0, MAX_IDLE));
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_inverses.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    logic        burst;
    int unsigned stall;
    int unsigned n;
    out_ready_i = 1'b0;
    burst       = 1'b0;
    n           = 0;
    @(posedge rst_ni);
    forever begin
      if (n % 50 == 0) burst = ($urandom_range(0, 3) == 0);
      stall = burst ? 0 : $urandom_range(0, MAX_IDLE);
      repeat (stall) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      n++;
    end
  end

  always @(posedge clk_i) begin
    inverse_t expected;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_inverses.size() == 0) begin
        $error("Result with no request outstanding: inverse %0d no_inverse %0d",
               inverse_o, no_inverse_o);
        error_count++;
      end else begin
        expected = pending_inverses.pop_front();
        if (inverse_o !== expected.inverse) begin
          $error("inverse: expected %0d, actual %0d", expected.inverse, inverse_o);
          error_count++;
        end
        if (no_inverse_o !== expected.no_inverse) begin
          $error("no_inverse: expected %0d, actual %0d", expected.no_inverse, no_inverse_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule

FILE: files.f
sv/mie_pkg.sv
sv/modular_inverse_extended_euclid.sv
dv/tb_top.sv
